// ===== design/apbb_pkg.sv =====
package apbb_pkg;

   localparam int NUM_REGS   = 6;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int FIELD_W    = 32;
   localparam int NUM_AXES   = 3;

   typedef logic [NUM_REGS-1:0][CSR_DATA_W-1:0] csr_regs_type;

   // register index codes, byte address is 8 * index
   typedef enum logic [2:0] {
      REG_ROW0_COLS01 = 3'd0,
      REG_ROW0_COLS23 = 3'd1,
      REG_ROW1_COLS01 = 3'd2,
      REG_ROW1_COLS23 = 3'd3,
      REG_ROW2_COLS01 = 3'd4,
      REG_ROW2_COLS23 = 3'd5
   } reg_idx_type;

   // identity matrix, no translation
   localparam csr_regs_type REG_RESET = {
      64'h0000_0000_0001_0000,   // row2_cols23
      64'h0000_0000_0000_0000,   // row2_cols01
      64'h0000_0000_0000_0000,   // row1_cols23
      64'h0001_0000_0000_0000,   // row1_cols01
      64'h0000_0000_0000_0000,   // row0_cols23
      64'h0000_0000_0001_0000    // row0_cols01
   };

   // transformed point handed to the box stage
   typedef struct packed {
      logic [NUM_AXES-1:0][FIELD_W-1:0] coord;
      logic                             restart;
      logic                             clipped;
   } xf_res_type;

endpackage

// ===== design/affine_point_bounding_box.sv =====
// Channel | Dir | Payload (low bit up)                           | Handshake
// req_    | in  | tdata: coord_x, coord_y, coord_z; tuser: restart | tvalid/tready
// rsp_    | out | tdata: min_x..z, max_x..z; tuser: box_valid, clipped | tvalid/tready
// csr_    | in  | six 64-bit matrix registers at byte address 8*i   | APB, pready high
//
// One request per cycle sustained while rsp_tready stays high; a request passes in turn through
// the input, nine products, row sums, scale and clamp, and box update registers.
// Only the min/max update closes a loop, from the box registers back to themselves.
// Synchronous reset loads the identity matrix and empties the box.
// Each stage holds under back-pressure and fills bubbles, so up to four more
// requests are taken while a result waits before req_tready drops.
module affine_point_bounding_box #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [95:0]                     req_tdata,   // coord_x, coord_y, coord_z
   input  logic [0:0]                      req_tuser,   // restart
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [191:0]                    rsp_tdata,   // min_x, min_y, min_z, max_x, max_y, max_z
   output logic [1:0]                      rsp_tuser,   // box_valid, clipped
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [apbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [apbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [apbb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import apbb_pkg::*;

   csr_regs_type regs;
   xf_res_type   xf_res;
   logic         xf_valid, xf_ready;
   logic [NUM_AXES-1:0][FIELD_W-1:0] box_low, box_high;
   logic         box_valid, clipped;

   apbb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .regs        (regs)
   );

   apbb_xform #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .coord_x   (req_tdata[31:0]),
      .coord_y   (req_tdata[63:32]),
      .coord_z   (req_tdata[95:64]),
      .restart   (req_tuser[0]),
      .regs      (regs),
      .out_valid (xf_valid),
      .out_ready (xf_ready),
      .out_res   (xf_res)
   );

   apbb_box u_box (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (xf_valid),
      .in_ready  (xf_ready),
      .in_res    (xf_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .box_low   (box_low),
      .box_high  (box_high),
      .box_valid (box_valid),
      .clipped   (clipped)
   );

   assign rsp_tdata = {box_high, box_low};
   assign rsp_tuser = {clipped, box_valid};

endmodule

// ===== design/apbb_csr.sv =====
module apbb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [apbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [apbb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [apbb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output apbb_pkg::csr_regs_type           regs
);
   import apbb_pkg::*;

   csr_regs_type regs_ff, regs_in;
   logic [2:0]   idx;
   logic         wr_en;

   assign idx        = csr_paddr[CSR_ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign regs       = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (wr_en && (idx == 3'(i))) begin
            regs_in[i] = csr_pwdata;
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      for (int i = 0; i < NUM_REGS; i++) begin
         if (idx == 3'(i)) begin
            csr_prdata = regs_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== design/apbb_xform.sv =====
module apbb_xform #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic [apbb_pkg::FIELD_W-1:0]      coord_x,
   input  logic [apbb_pkg::FIELD_W-1:0]      coord_y,
   input  logic [apbb_pkg::FIELD_W-1:0]      coord_z,
   input  logic                              restart,
   input  apbb_pkg::csr_regs_type            regs,
   output logic                              out_valid,
   input  logic                              out_ready,
   output apbb_pkg::xf_res_type              out_res
);
   import apbb_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int PW   = 2 * CW;
   localparam int SW   = PW + 2;
   localparam int NSTG = 4;

   localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

   // stages: 0 input, 1 products, 2 row sums, 3 scaled and saturated
   logic [NSTG-1:0]     vld_ff, vld_in;
   logic [NSTG-1:0]     stg_rdy;

   logic signed [CW-1:0] crd_ff  [NUM_AXES];
   logic signed [PW-1:0] prod_ff [NUM_AXES][NUM_AXES];
   logic signed [PW-1:0] prod_in [NUM_AXES][NUM_AXES];
   logic signed [SW-1:0] sum_ff  [NUM_AXES];
   logic signed [SW-1:0] sum_in  [NUM_AXES];
   logic [NSTG-2:0]      rst_ff;
   xf_res_type           res_ff, res_in;

   logic signed [CW-1:0] mat  [NUM_AXES][NUM_AXES];
   logic signed [CW-1:0] trans [NUM_AXES];

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         mat[r][0] = regs[2*r][CW-1:0];
         mat[r][1] = regs[2*r][32+CW-1:32];
         mat[r][2] = regs[2*r+1][CW-1:0];
         trans[r]  = regs[2*r+1][32+CW-1:32];
      end
   end

   always_comb begin
      stg_rdy[NSTG-1] = !vld_ff[NSTG-1] || out_ready;
      for (int k = NSTG-2; k >= 0; k--) begin
         stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
      end
      vld_in[0] = stg_rdy[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = stg_rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign in_ready  = stg_rdy[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_res   = res_ff;

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            prod_in[r][c] = PW'(mat[r][c]) * PW'(crd_ff[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         sum_in[r] = SW'(prod_ff[r][0]) + SW'(prod_ff[r][1]) + SW'(prod_ff[r][2]);
      end
   end

   // floor to Q.FRAC_BITS, add translation, clamp to the coordinate range
   always_comb begin
      logic signed [SW-1:0] tot;
      logic signed [CW-1:0] clamp;
      res_in         = '0;
      res_in.restart = rst_ff[2];
      for (int r = 0; r < NUM_AXES; r++) begin
         tot = (sum_ff[r] >>> FRAC_BITS) + SW'(trans[r]);
         if (tot > SW'(MAXV)) begin
            clamp          = MAXV;
            res_in.clipped = 1'b1;
         end else if (tot < SW'(MINV)) begin
            clamp          = MINV;
            res_in.clipped = 1'b1;
         end else begin
            clamp = tot[CW-1:0];
         end
         res_in.coord[r] = FIELD_W'(clamp);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && stg_rdy[0]) begin
         crd_ff[0] <= coord_x[CW-1:0];
         crd_ff[1] <= coord_y[CW-1:0];
         crd_ff[2] <= coord_z[CW-1:0];
         rst_ff[0] <= restart;
      end
      if (vld_ff[0] && stg_rdy[1]) begin
         prod_ff   <= prod_in;
         rst_ff[1] <= rst_ff[0];
      end
      if (vld_ff[1] && stg_rdy[2]) begin
         sum_ff    <= sum_in;
         rst_ff[2] <= rst_ff[1];
      end
      if (vld_ff[2] && stg_rdy[3]) begin
         res_ff <= res_in;
      end
   end

endmodule

// ===== design/apbb_box.sv =====
module apbb_box (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  apbb_pkg::xf_res_type                   in_res,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [apbb_pkg::NUM_AXES-1:0][apbb_pkg::FIELD_W-1:0] box_low,
   output logic [apbb_pkg::NUM_AXES-1:0][apbb_pkg::FIELD_W-1:0] box_high,
   output logic                                   box_valid,
   output logic                                   clipped
);
   import apbb_pkg::*;

   // the box registers double as the result register
   logic signed [FIELD_W-1:0] low_ff  [NUM_AXES];
   logic signed [FIELD_W-1:0] low_in  [NUM_AXES];
   logic signed [FIELD_W-1:0] high_ff [NUM_AXES];
   logic signed [FIELD_W-1:0] high_in [NUM_AXES];
   logic                      filled_ff, filled_in;
   logic                      vld_ff, vld_in;
   logic                      clip_ff;
   logic                      take;

   assign in_ready  = !vld_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = vld_ff;
   assign box_valid = filled_ff;
   assign clipped   = clip_ff;

   always_comb begin
      logic signed [FIELD_W-1:0] pt;
      filled_in = filled_ff;
      vld_in    = in_ready ? in_valid : vld_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         pt         = in_res.coord[i];
         low_in[i]  = low_ff[i];
         high_in[i] = high_ff[i];
         if (take) begin
            if (in_res.restart || !filled_ff) begin
               low_in[i]  = pt;
               high_in[i] = pt;
            end else begin
               if (pt < low_ff[i]) begin
                  low_in[i] = pt;
               end
               if (pt > high_ff[i]) begin
                  high_in[i] = pt;
               end
            end
         end
      end
      if (take) begin
         filled_in = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         box_low[i]  = low_ff[i];
         box_high[i] = high_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= 1'b0;
         filled_ff <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            low_ff[i]  <= '0;
            high_ff[i] <= '0;
         end
      end else begin
         vld_ff    <= vld_in;
         filled_ff <= filled_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         clip_ff <= in_res.clipped;
      end
   end

endmodule
